// ----- design/touchpad_to_mouse_delta_unit_assert.svh -----
// assertion helpers for the top-level design file
`ifndef TOUCHPAD_TO_MOUSE_DELTA_UNIT_ASSERT_SVH
`define TOUCHPAD_TO_MOUSE_DELTA_UNIT_ASSERT_SVH

// same-cycle implication
`define TMD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication
`define TMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- design/tmd_pkg.sv -----
package tmd_pkg;

	localparam int NUM_SAMPLES = 3;
	localparam int COORD_W     = 12;
	localparam int DELTA_W     = 13;
	localparam int CNT_W       = 2;
	localparam int IDX_W       = 2;
	localparam int QDEPTH      = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_DELTA_MIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DELTA_MAX = 2'd1;

	localparam logic signed [DELTA_W-1:0] DELTA_MIN_RST = -13'sd127;
	localparam logic [COORD_W-1:0]        DELTA_MAX_RST = 12'd127;

	typedef struct packed {
		logic               lifted;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} sample_t;

	// one classified report as it sits in the queue
	typedef struct packed {
		logic                        click;
		logic                        changed;
		logic [IDX_W-1:0]            last_idx;
		sample_t [NUM_SAMPLES-1:0]   samples;
	} report_t;

	typedef enum logic {
		BK_SAMPLE,
		BK_FLUSH
	} back_state_t;

	typedef struct packed {
		logic busy;
		logic flushing;
	} back_stat_t;

endpackage

// ----- design/tmd_front.sv -----
module tmd_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         pad_click,
	input  logic [tmd_pkg::CNT_W-1:0]    entry_count,
	input  logic                         s0_lifted,
	input  logic [tmd_pkg::COORD_W-1:0]  s0_x,
	input  logic [tmd_pkg::COORD_W-1:0]  s0_y,
	input  logic                         s1_lifted,
	input  logic [tmd_pkg::COORD_W-1:0]  s1_x,
	input  logic [tmd_pkg::COORD_W-1:0]  s1_y,
	input  logic                         s2_lifted,
	input  logic [tmd_pkg::COORD_W-1:0]  s2_x,
	input  logic [tmd_pkg::COORD_W-1:0]  s2_y,
	input  logic                         q_full,
	output logic                         push,
	output tmd_pkg::report_t             entry
);

	logic click_held_q;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		entry.click      = pad_click;
		entry.changed    = pad_click != click_held_q;
		// a count of zero means one sample
		entry.last_idx   = (entry_count == '0) ? '0 : entry_count - 1'b1;
		entry.samples[0] = '{lifted: s0_lifted, x: s0_x, y: s0_y};
		entry.samples[1] = '{lifted: s1_lifted, x: s1_x, y: s1_y};
		entry.samples[2] = '{lifted: s2_lifted, x: s2_x, y: s2_y};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			click_held_q <= 1'b0;
		end else if (push) begin
			click_held_q <= pad_click;
		end
	end

endmodule

// ----- design/tmd_queue.sv -----
module tmd_queue #(
	parameter int DEPTH = tmd_pkg::QDEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tmd_pkg::report_t wr_entry,
	input  logic             pop,
	output tmd_pkg::report_t head,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tmd_pkg::report_t slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	assign full  = fill_q == CNT_W'(DEPTH);
	assign empty = fill_q == '0;
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/tmd_back.sv -----
module tmd_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tmd_pkg::report_t                    head,
	input  logic                                q_empty,
	output logic                                pop,
	input  logic signed [tmd_pkg::DELTA_W-1:0]  delta_min,
	input  logic [tmd_pkg::COORD_W-1:0]         delta_max,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                left_button,
	output logic signed [tmd_pkg::DELTA_W-1:0]  move_x,
	output logic signed [tmd_pkg::DELTA_W-1:0]  move_y,
	output logic                                final_event,
	output tmd_pkg::back_stat_t                 stat
);

	localparam int DW = tmd_pkg::DELTA_W;
	localparam int CW = tmd_pkg::COORD_W;

	tmd_pkg::back_state_t state_q, state_d;

	logic [tmd_pkg::IDX_W-1:0] idx_q;
	logic                      chg_q;
	logic                      down_q;
	logic [CW-1:0]             prev_x_q;
	logic [CW-1:0]             prev_y_q;

	// held event, sent once the next one appears or the report ends
	logic                      pend_v_q;
	logic                      pend_btn_q;
	logic signed [DW-1:0]      pend_dx_q;
	logic signed [DW-1:0]      pend_dy_q;

	logic                      out_v_q;
	logic                      out_btn_q;
	logic signed [DW-1:0]      out_dx_q;
	logic signed [DW-1:0]      out_dy_q;
	logic                      out_fin_q;

	tmd_pkg::sample_t          smp;
	logic signed [DW-1:0]      dx_raw;
	logic signed [DW-1:0]      dy_raw;
	logic signed [DW-1:0]      dx;
	logic signed [DW-1:0]      dy;
	logic                      cur_chg;
	logic                      ev;
	logic                      slot;
	logic                      step;
	logic                      emit_mid;
	logic                      emit_fin;

	function automatic logic signed [DW-1:0] clamp(
		input logic signed [DW-1:0] d,
		input logic signed [DW-1:0] lo,
		input logic [CW-1:0]        hi
	);
		logic signed [DW-1:0] his;
		his = $signed({1'b0, hi});
		if (d < lo) begin
			return lo;
		end else if (d > his) begin
			return his;
		end
		return d;
	endfunction

	always_comb begin
		smp     = head.samples[idx_q];
		dx_raw  = $signed({1'b0, smp.x}) - $signed({1'b0, prev_x_q});
		dy_raw  = $signed({1'b0, smp.y}) - $signed({1'b0, prev_y_q});
		dx      = '0;
		dy      = '0;
		if (!smp.lifted && down_q) begin
			dx = clamp(dx_raw, delta_min, delta_max);
			dy = clamp(dy_raw, delta_min, delta_max);
		end
		cur_chg = (idx_q == '0) ? head.changed : chg_q;
		ev      = cur_chg || (dx != '0) || (dy != '0);
		slot    = !out_v_q || out_ready;
	end

	always_comb begin
		state_d  = state_q;
		step     = 1'b0;
		emit_mid = 1'b0;
		emit_fin = 1'b0;
		pop      = 1'b0;
		case (state_q)
			tmd_pkg::BK_SAMPLE: begin
				if (!q_empty && !(ev && pend_v_q && !slot)) begin
					step     = 1'b1;
					emit_mid = ev && pend_v_q;
					if (idx_q == head.last_idx) begin
						state_d = tmd_pkg::BK_FLUSH;
					end
				end
			end
			tmd_pkg::BK_FLUSH: begin
				if (!pend_v_q || slot) begin
					emit_fin = pend_v_q;
					pop      = 1'b1;
					state_d  = tmd_pkg::BK_SAMPLE;
				end
			end
			default: begin
				state_d = tmd_pkg::BK_SAMPLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tmd_pkg::BK_SAMPLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			chg_q    <= 1'b0;
			down_q   <= 1'b0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (step) begin
				if (!smp.lifted) begin
					down_q   <= 1'b1;
					prev_x_q <= smp.x;
					prev_y_q <= smp.y;
				end else begin
					down_q <= 1'b0;
				end
				chg_q <= ev ? 1'b0 : cur_chg;
				if (ev) begin
					pend_v_q <= 1'b1;
				end
				if (idx_q != head.last_idx) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (pop) begin
				idx_q    <= '0;
				pend_v_q <= 1'b0;
			end
			if (emit_mid || emit_fin) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && ev) begin
			pend_btn_q <= head.click;
			pend_dx_q  <= dx;
			pend_dy_q  <= dy;
		end
		if (emit_mid || emit_fin) begin
			out_btn_q <= pend_btn_q;
			out_dx_q  <= pend_dx_q;
			out_dy_q  <= pend_dy_q;
			out_fin_q <= emit_fin;
		end
	end

	assign out_valid     = out_v_q;
	assign left_button   = out_btn_q;
	assign move_x        = out_dx_q;
	assign move_y        = out_dy_q;
	assign final_event   = out_fin_q;
	assign stat.busy     = !q_empty;
	assign stat.flushing = state_q == tmd_pkg::BK_FLUSH;

endmodule

// ----- design/touchpad_to_mouse_delta_unit.sv -----
// channel   direction  handshake              beat contents
// in        input      in_valid / in_ready    pad_click, entry_count, s0..s2 lifted/x/y
// out       output     out_valid / out_ready  left_button, move_x, move_y, final_event
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// In the back unit a report runs each of its samples in turn (a count of zero
// runs one sample) through the shared delta/clamp step, then a flush state
// releases the held event with final_event set. The front takes a beat per
// cycle into a two-entry queue while it has room, so reports are taken while
// the back is still busy. Reset clears click, finger and queue state and
// loads the default limits. A stalled out channel stalls the back only while
// an event is held and a second event or the end of the report needs the
// output register.
`include "touchpad_to_mouse_delta_unit_assert.svh"

module touchpad_to_mouse_delta_unit #(
	parameter int QUEUE_DEPTH = tmd_pkg::QDEPTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 pad_click,
	input  logic [tmd_pkg::CNT_W-1:0]            entry_count,
	input  logic                                 s0_lifted,
	input  logic [tmd_pkg::COORD_W-1:0]          s0_x,
	input  logic [tmd_pkg::COORD_W-1:0]          s0_y,
	input  logic                                 s1_lifted,
	input  logic [tmd_pkg::COORD_W-1:0]          s1_x,
	input  logic [tmd_pkg::COORD_W-1:0]          s1_y,
	input  logic                                 s2_lifted,
	input  logic [tmd_pkg::COORD_W-1:0]          s2_x,
	input  logic [tmd_pkg::COORD_W-1:0]          s2_y,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 left_button,
	output logic signed [tmd_pkg::DELTA_W-1:0]   move_x,
	output logic signed [tmd_pkg::DELTA_W-1:0]   move_y,
	output logic                                 final_event,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [tmd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [tmd_pkg::CFG_DATA_W-1:0]       cfg_data
);

	logic signed [tmd_pkg::DELTA_W-1:0] delta_min_q;
	logic [tmd_pkg::COORD_W-1:0]        delta_max_q;

	tmd_pkg::report_t    wr_entry;
	tmd_pkg::report_t    head;
	tmd_pkg::back_stat_t stat;
	logic                push;
	logic                pop;
	logic                q_full;
	logic                q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_min_q <= tmd_pkg::DELTA_MIN_RST;
			delta_max_q <= tmd_pkg::DELTA_MAX_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				tmd_pkg::CFG_DELTA_MIN: delta_min_q <= $signed(cfg_data);
				tmd_pkg::CFG_DELTA_MAX: delta_max_q <= cfg_data[tmd_pkg::COORD_W-1:0];
				default: ;
			endcase
		end
	end

	tmd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pad_click   (pad_click),
		.entry_count (entry_count),
		.s0_lifted   (s0_lifted),
		.s0_x        (s0_x),
		.s0_y        (s0_y),
		.s1_lifted   (s1_lifted),
		.s1_x        (s1_x),
		.s1_y        (s1_y),
		.s2_lifted   (s2_lifted),
		.s2_x        (s2_x),
		.s2_y        (s2_y),
		.q_full      (q_full),
		.push        (push),
		.entry       (wr_entry)
	);

	tmd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	tmd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_empty     (q_empty),
		.pop         (pop),
		.delta_min   (delta_min_q),
		.delta_max   (delta_max_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.left_button (left_button),
		.move_x      (move_x),
		.move_y      (move_y),
		.final_event (final_event),
		.stat        (stat)
	);

	`TMD_ASSERT_NOW(a_pop_not_empty, clk, arst_n, pop, stat.busy)
	`TMD_ASSERT_NOW(a_pop_in_flush, clk, arst_n, pop, stat.flushing)
	`TMD_ASSERT_NEXT(a_accept_queues, clk, arst_n, in_valid && in_ready, !q_empty)

endmodule
